// ===== rtl/dstwr_pkg.sv =====
// dstwr_pkg: constants, codes and control structs of the two-way ranging anchor.
// No dependencies; used by the interfaces, the divider and the top level.
package dstwr_pkg;

  localparam int TS_W_DEF   = 40;
  localparam int ADDR_W_DEF = 16;
  localparam int OP_W       = 3;
  localparam int RD_W       = 40;   // reply_delay register
  localparam int TPDU_W     = 16;   // ticks_per_distance_unit register
  localparam int FLIGHT_W   = 41;
  localparam int DIST_W     = 32;
  localparam int CHUNK_W    = 16;   // multiplier digit width
  localparam int CNT_W      = 7;    // divider step count, covers 2 * 48 steps

  localparam logic [TPDU_W-1:0] TPDU_RESET = 16'd2;
  localparam logic [7:0]        TAG_RESET  = 8'hFF;

  localparam logic [OP_W-1:0] OP_POLL  = 3'd0;
  localparam logic [OP_W-1:0] OP_RESP  = 3'd1;
  localparam logic [OP_W-1:0] OP_FINAL = 3'd2;
  localparam logic [OP_W-1:0] OP_OTHER = 3'd3;
  localparam logic [OP_W-1:0] OP_FAIL  = 3'd4;

  localparam logic [1:0] STAGE_POLL  = 2'd0;
  localparam logic [1:0] STAGE_RESP  = 2'd1;
  localparam logic [1:0] STAGE_FINAL = 2'd2;

  localparam logic KIND_RESPONSE = 1'b0;
  localparam logic KIND_DISTANCE = 1'b1;

  localparam logic REG_REPLY_DELAY = 1'b0;
  localparam logic REG_TICKS       = 1'b1;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/dstwr_if.sv =====
// dstwr_if: valid/ready channels for event words, result words and register writes.
// Depends on dstwr_pkg for field widths.
interface dstwr_evt_if #(
  parameter int TW = dstwr_pkg::TS_W_DEF,
  parameter int AW = dstwr_pkg::ADDR_W_DEF
);
  logic                        valid;
  logic                        ready;
  logic [dstwr_pkg::OP_W-1:0]  operation;
  logic [TW-1:0]               event_time;
  logic [AW-1:0]               source_address;
  logic [TW-1:0]               tag_round_time;
  logic [TW-1:0]               tag_reply_time;
  modport source (output valid, operation, event_time, source_address, tag_round_time,
                  tag_reply_time, input ready);
  modport sink (input valid, operation, event_time, source_address, tag_round_time,
                tag_reply_time, output ready);
endinterface

interface dstwr_res_if #(
  parameter int TW = dstwr_pkg::TS_W_DEF,
  parameter int AW = dstwr_pkg::ADDR_W_DEF
);
  logic                               valid;
  logic                               ready;
  logic                               result_kind;
  logic [AW-1:0]                      destination;
  logic [TW-1:0]                      transmit_time;
  logic signed [dstwr_pkg::FLIGHT_W-1:0] flight_time;
  logic signed [dstwr_pkg::DIST_W-1:0]   distance;
  logic                               range_error;
  modport source (output valid, result_kind, destination, transmit_time, flight_time,
                  distance, range_error, input ready);
  modport sink (input valid, result_kind, destination, transmit_time, flight_time,
                distance, range_error, output ready);
endinterface

interface dstwr_cfg_if;
  logic                       valid;
  logic                       ready;
  logic                       index;
  logic [dstwr_pkg::RD_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/dstwr_div.sv =====
// dstwr_div: restoring divider, one quotient bit a cycle, step count set per request.
// Dividend is taken MSB first; quotient of the top 'steps' bits lands in the low bits.
// Depends on dstwr_pkg.
module dstwr_div #(
  parameter int NW = 80,
  parameter int DW = 42
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dstwr_pkg::div_req_t  req,
  input  logic [NW-1:0]        dividend,
  input  logic [DW-1:0]        divisor,
  output dstwr_pkg::div_stat_t stat,
  output logic [NW-1:0]        quotient
);

  logic [DW-1:0]             rem;
  logic [NW-1:0]             dvd;
  logic [NW-1:0]             quo;
  logic [DW-1:0]             dvr;
  logic [dstwr_pkg::CNT_W-1:0] cnt;
  logic                      busy;
  logic                      done;
  logic [DW:0]               trial;
  logic [DW:0]               diff;
  logic                      ge;
  logic [DW-1:0]             rem_next;

  always_comb begin
    trial    = {rem, dvd[NW-1]};
    diff     = trial - {1'b0, dvr};
    ge       = trial >= {1'b0, dvr};
    rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
        rem  <= '0;
        dvd  <= dividend;
        quo  <= '0;
        dvr  <= divisor;
      end else if (busy) begin
        rem <= rem_next;
        dvd <= {dvd[NW-2:0], 1'b0};
        quo <= {quo[NW-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == dstwr_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk) disable iff (rst) busy |-> !req.start)
    else $error("divider restarted while busy");
  a_done_once: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("divider done held for two cycles");
  a_steps_nonzero: assert property (@(posedge clk) disable iff (rst)
    req.start |-> req.steps != '0)
    else $error("divider started with no steps");
`endif

endmodule

// ===== rtl/ds_twr_anchor_ranging.sv =====
// Two-way ranging anchor: response orders and distance results from radio event words.
// Flow: a poll passes through the emit state to its response order; a final in the
// final stage goes through the two multiply states, the subtract state, both passes
// of the shared divider (flight time, then distance) and then the emit state.
// One event at a time: evt.ready is high only while the sequencer is idle.
// Reset (rst, synchronous): poll stage, tag address 0xFF, times zero, registers to defaults.
module ds_twr_anchor_ranging #(
  parameter int TIMESTAMP_WIDTH = dstwr_pkg::TS_W_DEF,
  parameter int ADDRESS_WIDTH   = dstwr_pkg::ADDR_W_DEF
) (
  input  logic clk,
  input  logic rst,
  dstwr_evt_if.sink   evt,
  dstwr_res_if.source res,
  dstwr_cfg_if.sink   cfg
);

  localparam int TW   = TIMESTAMP_WIDTH;
  localparam int AW   = ADDRESS_WIDTH;
  localparam int FW   = dstwr_pkg::FLIGHT_W;
  localparam int DSW  = dstwr_pkg::DIST_W;
  localparam int CW   = dstwr_pkg::CHUNK_W;
  localparam int NCH  = (TW + CW - 1) / CW;
  localparam int PW   = TW + CW * NCH;
  localparam int MCW  = $clog2(NCH) + 1;
  localparam int SW   = TW + 2;
  localparam int NW   = (2 * TW > FW) ? 2 * TW : FW;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MULA = 4'd1;
  localparam logic [3:0] ST_MULB = 4'd2;
  localparam logic [3:0] ST_SUB  = 4'd3;
  localparam logic [3:0] ST_DIV1 = 4'd4;
  localparam logic [3:0] ST_DIV2 = 4'd5;
  localparam logic [3:0] ST_EMIT = 4'd6;

  localparam logic [FW-1:0] FLIGHT_POS_SAT = {1'b0, {(FW-1){1'b1}}};
  localparam logic [FW-1:0] FLIGHT_NEG_SAT = {1'b1, {(FW-1){1'b0}}};
  localparam logic [FW-1:0] DIST_POS_LIM   = FW'({1'b0, {(DSW-1){1'b1}}});
  localparam logic [FW-1:0] DIST_NEG_LIM   = FW'({1'b1, {(DSW-1){1'b0}}});

  logic [3:0]                    state;
  logic [1:0]                    stage;
  logic [AW-1:0]                 tag_address;
  logic [TW-1:0]                 poll_time;
  logic [TW-1:0]                 resp_time;
  logic [dstwr_pkg::RD_W-1:0]    reply_delay;
  logic [dstwr_pkg::TPDU_W-1:0]  tpdu;

  logic [TW-1:0]   ry1;
  logic [TW-1:0]   ry2;
  logic [SW-1:0]   sum;
  logic [TW-1:0]   mul_a;
  logic [PW-1:0]   prod;
  logic [MCW-1:0]  mcnt;
  logic [2*TW-1:0] pa;
  logic [2*TW-1:0] pb;
  logic            neg;

  logic            p_kind;
  logic [AW-1:0]   p_dest;
  logic [TW-1:0]   p_tx;
  logic [FW-1:0]   flight;
  logic [DSW-1:0]  dist_val;
  logic            err;

  logic accept;
  logic [TW-1:0] rd2_w;
  logic [TW-1:0] ry1_w;
  logic [SW-1:0] sum_w;
  logic [dstwr_pkg::RD_W+TW-1:0] rd_wide;
  logic [TW-1:0] rd_ext;

  logic [TW+CW-1:0]   digit_prod;
  logic [TW+CW-1:0]   psum;
  logic [PW+CW-1:0]   pshift;
  logic [PW-1:0]      prod_next;

  logic [2*TW-1:0]    mag;
  logic [NW+FW-1:0]   fm_aligned;
  logic               q_sat;
  logic [FW-1:0]      fm;
  logic [FW-1:0]      dm;
  logic [FW-1:0]      dm_sat;
  logic               d_sat;

  dstwr_pkg::div_req_t  div_req;
  dstwr_pkg::div_stat_t div_stat;
  logic [NW-1:0]        div_dividend;
  logic [SW-1:0]        div_divisor;
  logic [NW-1:0]        div_q;

  assign accept    = evt.valid && evt.ready;
  assign evt.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;

  always_comb begin
    rd2_w   = evt.event_time - resp_time;
    ry1_w   = resp_time - poll_time;
    sum_w   = SW'(evt.tag_round_time) + SW'(rd2_w) + SW'(ry1_w) + SW'(evt.tag_reply_time);
    rd_wide = {{TW{1'b0}}, reply_delay};
    rd_ext  = rd_wide[TW-1:0];
  end

  // one 16-bit digit of the multiplier per cycle, partial product shifted out low
  always_comb begin
    digit_prod = mul_a * prod[CW-1:0];
    psum       = (TW+CW)'(prod[PW-1:CW*NCH]) + digit_prod;
    pshift     = {psum, prod[CW*NCH-1:0]};
    prod_next  = pshift[PW+CW-1:CW];
  end

  // magnitude is taken from the products directly: neg is only registered as the divide starts
  always_comb begin
    mag        = (pa < pb) ? (pb - pa) : (pa - pb);
    q_sat      = div_q[NW-1:FW-1] != '0;
    fm         = q_sat ? (neg ? FLIGHT_NEG_SAT : FLIGHT_POS_SAT) : div_q[FW-1:0];
    fm_aligned = {fm, {NW{1'b0}}};
    dm         = div_q[FW-1:0];
    d_sat      = neg ? (dm > DIST_NEG_LIM) : (dm > DIST_POS_LIM);
    dm_sat     = d_sat ? (neg ? DIST_NEG_LIM : DIST_POS_LIM) : dm;
  end

  always_comb begin
    div_req.start = 1'b0;
    div_req.steps = dstwr_pkg::CNT_W'(NW);
    div_dividend  = NW'(mag);
    div_divisor   = sum;
    unique case (state)
      ST_SUB: begin
        div_req.start = (sum != '0);
      end
      ST_DIV1: begin
        div_req.start = div_stat.done && (tpdu != '0);
        div_req.steps = dstwr_pkg::CNT_W'(FW);
        div_dividend  = fm_aligned[NW+FW-1:FW];
        div_divisor   = SW'(tpdu);
      end
      default: begin
      end
    endcase
  end

  dstwr_div #(.NW(NW), .DW(SW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      reply_delay <= '0;
      tpdu        <= dstwr_pkg::TPDU_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        dstwr_pkg::REG_REPLY_DELAY: reply_delay <= cfg.data;
        dstwr_pkg::REG_TICKS:       tpdu <= cfg.data[dstwr_pkg::TPDU_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      stage       <= dstwr_pkg::STAGE_POLL;
      tag_address <= AW'(dstwr_pkg::TAG_RESET);
      poll_time   <= '0;
      resp_time   <= '0;
      res.valid   <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        res.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            case (evt.operation)
              dstwr_pkg::OP_POLL: begin
                stage       <= dstwr_pkg::STAGE_RESP;
                tag_address <= evt.source_address;
                poll_time   <= evt.event_time;
                p_kind      <= dstwr_pkg::KIND_RESPONSE;
                p_dest      <= evt.source_address;
                p_tx        <= evt.event_time + rd_ext;
                flight      <= '0;
                dist_val    <= '0;
                err         <= 1'b0;
                state       <= ST_EMIT;
              end
              dstwr_pkg::OP_RESP: begin
                stage     <= dstwr_pkg::STAGE_FINAL;
                resp_time <= evt.event_time;
              end
              dstwr_pkg::OP_FINAL: begin
                if (stage == dstwr_pkg::STAGE_FINAL) begin
                  stage <= dstwr_pkg::STAGE_POLL;
                  ry1   <= ry1_w;
                  ry2   <= evt.tag_reply_time;
                  sum   <= sum_w;
                  mul_a <= evt.tag_round_time;
                  prod  <= PW'(rd2_w);
                  mcnt  <= '0;
                  state <= ST_MULA;
                end
              end
              dstwr_pkg::OP_FAIL: begin
                stage <= dstwr_pkg::STAGE_POLL;
              end
              default: begin
              end
            endcase
          end
        end
        ST_MULA: begin
          prod <= prod_next;
          mcnt <= mcnt + 1'b1;
          if (mcnt == MCW'(NCH - 1)) begin
            pa    <= prod_next[2*TW-1:0];
            prod  <= PW'(ry2);
            mul_a <= ry1;
            mcnt  <= '0;
            state <= ST_MULB;
          end
        end
        ST_MULB: begin
          prod <= prod_next;
          mcnt <= mcnt + 1'b1;
          if (mcnt == MCW'(NCH - 1)) begin
            pb    <= prod_next[2*TW-1:0];
            state <= ST_SUB;
          end
        end
        ST_SUB: begin
          neg      <= pa < pb;
          p_kind   <= dstwr_pkg::KIND_DISTANCE;
          p_dest   <= '0;
          p_tx     <= '0;
          flight   <= '0;
          dist_val <= '0;
          err      <= 1'b0;
          if (sum == '0) begin
            err   <= 1'b1;
            state <= ST_EMIT;
          end else begin
            state <= ST_DIV1;
          end
        end
        ST_DIV1: begin
          if (div_stat.done) begin
            flight <= neg ? (~fm + 1'b1) : fm;
            err    <= q_sat;
            if (tpdu == '0) begin
              err   <= 1'b1;
              state <= ST_EMIT;
            end else begin
              state <= ST_DIV2;
            end
          end
        end
        ST_DIV2: begin
          if (div_stat.done) begin
            dist_val <= neg ? (~dm_sat[DSW-1:0] + 1'b1) : dm_sat[DSW-1:0];
            err      <= err | d_sat;
            state    <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!res.valid || res.ready) begin
            res.valid         <= 1'b1;
            res.result_kind   <= p_kind;
            res.destination   <= p_dest;
            res.transmit_time <= p_tx;
            res.flight_time   <= flight;
            res.distance      <= dist_val;
            res.range_error   <= err;
            state             <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == ST_DIV1 || state == ST_DIV2))
    else $error("divider finished outside a divide step");
  a_response_fields: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.result_kind == dstwr_pkg::KIND_RESPONSE |->
      res.flight_time == '0 && res.distance == '0 && !res.range_error)
    else $error("response word carries range fields");
  a_distance_fields: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.result_kind == dstwr_pkg::KIND_DISTANCE |->
      res.destination == '0 && res.transmit_time == '0)
    else $error("distance word carries response fields");
  a_final_to_poll: assert property (@(posedge clk) disable iff (rst)
    accept && evt.operation == dstwr_pkg::OP_FINAL && stage == dstwr_pkg::STAGE_FINAL |=>
      stage == dstwr_pkg::STAGE_POLL && state == ST_MULA)
    else $error("final word did not start a range computation");
`endif

endmodule
